>>> hdl/lsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsr_pkg: shared types and constants for the level-set reinit stencil
// Job record passed from the stencil front end to the arithmetic back end,
// register indexes and state encodings.
// ----------------------------------------------------------------------------
package lsr_pkg;

  typedef logic signed [23:0] sample_t;

  // One pixel to evaluate: center, left, right, up, down and result flags
  typedef struct packed {
    sample_t v;
    sample_t l;
    sample_t r;
    sample_t u;
    sample_t d;
    logic    frame_end;
    logic    last;
  } job_t;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  localparam int unsigned SQ_ITERS  = 26;
  localparam int unsigned DIV_ITERS = 51;

  localparam logic [49:0] ONE_Q24 = 50'd16777216;
  localparam logic signed [26:0] ONE_Q12 = 27'sd4096;

  typedef enum logic [1:0] {
    F_IDLE,
    F_READ,
    F_ISSUE,
    F_WRITE
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_PREP,
    B_MUL,
    B_SQRT,
    B_MULQ,
    B_ADDQ,
    B_DIV,
    B_DONE,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

>>> hdl/lsr_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsr_fifo: job queue
// Short first-in first-out queue that decouples the stencil front end from
// the arithmetic back end.
// ----------------------------------------------------------------------------
module lsr_fifo
  import lsr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_data,
  output logic      full,
  input  wire logic pop,
  output job_t      pop_data,
  output logic      empty
);

  job_t                 mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr;
  logic [FIFO_AW-1:0]   rd_ptr;
  logic [FIFO_AW:0]     count;

  assign full     = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + (FIFO_AW+1)'(1);
        2'b01:   count <= count - (FIFO_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/lsr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsr_front: stencil front end
// Tracks raster position, keeps the two row buffers and builds zero to three
// stencil jobs per sample, pushed into the job queue.
// ----------------------------------------------------------------------------
module lsr_front
  import lsr_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire sample_t     phi_in,
  input  wire logic [10:0] image_width,
  input  wire logic [11:0] image_height,
  output logic             job_push,
  output job_t             job,
  input  wire logic        job_full
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = (AW + 1 > 11) ? AW + 1 : 11;
  localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

  front_state_t state, state_next;

  logic [23:0] upper_mem  [MAX_WIDTH];
  logic [23:0] middle_mem [MAX_WIDTH];

  logic [WW-1:0] iw, w_eff, w_m1;
  logic [11:0]   h_eff, h_m1;
  logic [AW-1:0] col_cnt, c_cur;
  logic [11:0]   row_cnt, r_cur;

  sample_t       v_l, rs0, rs1;
  logic [AW-1:0] c_l;
  logic          is_row0, is_last_row, is_last_col, c_nz, c_ge2, has_right;
  sample_t       up_q0, up_q1, mid_q0, mid_q1;
  logic [1:0]    idx;
  logic [2:0]    en;
  logic          advance;
  sample_t       ctr, left, right;
  logic          accept;

  assign iw = WW'(image_width);

  always_comb begin
    w_eff = (iw < WW'(2)) ? WW'(2) : ((iw > MAXW) ? MAXW : iw);
    w_m1  = w_eff - WW'(1);
    h_eff = (image_height < 12'd2) ? 12'd2 : image_height;
    h_m1  = h_eff - 12'd1;
    c_cur = (WW'(col_cnt) < w_eff) ? col_cnt : w_m1[AW-1:0];
    r_cur = (row_cnt < h_eff) ? row_cnt : h_m1;
  end

  assign accept = in_valid && in_ready;

  // stencil neighbors, clamped at the left and right edges
  always_comb begin
    ctr   = mid_q0;
    left  = c_nz ? up_q1 : mid_q0;
    right = has_right ? mid_q1 : mid_q0;
    en    = {is_last_row && is_last_col, is_last_row && c_nz, 1'b1};
    job   = '0;
    case (idx)
      2'd0: begin
        job.v = ctr;  job.l = left;  job.r = right;  job.u = up_q0;  job.d = v_l;
        job.frame_end = 1'b0;
        job.last      = !en[1] && !en[2];
      end
      2'd1: begin
        job.v = rs0;  job.l = c_ge2 ? rs1 : rs0;  job.r = v_l;
        job.u = up_q1;  job.d = rs0;
        job.frame_end = 1'b0;
        job.last      = !en[2];
      end
      2'd2: begin
        job.v = v_l;  job.l = rs0;  job.r = v_l;  job.u = ctr;  job.d = v_l;
        job.frame_end = 1'b1;
        job.last      = 1'b1;
      end
      default: begin
        job = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    job_push   = 1'b0;
    advance    = 1'b0;
    case (state)
      F_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = F_READ;
        end
      end
      F_READ: begin
        state_next = is_row0 ? F_WRITE : F_ISSUE;
      end
      F_ISSUE: begin
        job_push = en[idx] && !job_full;
        advance  = job_push || !en[idx];
        if (advance && idx == 2'd2) begin
          state_next = F_WRITE;
        end
      end
      F_WRITE: begin
        state_next = F_IDLE;
      end
      default: begin
        state_next = F_IDLE;
      end
    endcase
  end

  // raster position and sample history
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      rs0     <= '0;
      rs1     <= '0;
    end else begin
      if (accept) begin
        if (WW'(c_cur) >= w_m1) begin
          col_cnt <= '0;
          row_cnt <= (r_cur >= h_m1) ? 12'd0 : r_cur + 12'd1;
        end else begin
          col_cnt <= c_cur + AW'(1);
          row_cnt <= r_cur;
        end
      end
      if (state == F_WRITE) begin
        rs1 <= rs0;
        rs0 <= v_l;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      v_l         <= phi_in;
      c_l         <= c_cur;
      is_row0     <= (r_cur == 12'd0);
      is_last_row <= (r_cur == h_m1);
      is_last_col <= (WW'(c_cur) == w_m1);
      c_nz        <= (c_cur != '0);
      c_ge2       <= (WW'(c_cur) >= WW'(2));
      has_right   <= (WW'(c_cur) < w_m1);
    end
    if (state == F_READ) begin
      idx <= 2'd0;
    end else if (advance) begin
      idx <= idx + 2'd1;
    end
  end

  // row buffers: read in the read state, update in the write state
  always_ff @(posedge clk) begin
    if (state == F_READ) begin
      up_q0  <= upper_mem[c_l];
      up_q1  <= upper_mem[c_l - AW'(1)];
      mid_q0 <= middle_mem[c_l];
      mid_q1 <= middle_mem[c_l + AW'(1)];
    end
    if (state == F_WRITE) begin
      upper_mem[c_l]  <= is_row0 ? v_l : mid_q0;
      middle_mem[c_l] <= v_l;
    end
  end

endmodule
`default_nettype wire

>>> hdl/lsr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsr_back: reinitialization arithmetic
// Upwind gradient on one shared multiplier, two bit-serial square roots and a
// restoring divider; one job at a time into the output register.
// ----------------------------------------------------------------------------
module lsr_back
  import lsr_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_empty,
  output logic      job_pop,
  input  wire job_t job_in,
  output logic      out_valid,
  input  wire logic out_ready,
  output sample_t   phi_out,
  output logic      frame_end,
  output logic      last
);

  back_state_t state, state_next;

  job_t        jb;
  logic [5:0]  cnt;
  logic [24:0] x0, x1, x2, x3;
  logic [23:0] vm;
  logic [49:0] prod_r, hold0, m1, sum, rad2;
  logic [51:0] sq_arg;
  logic [27:0] sq_rem;
  logic [25:0] sq_root;
  logic        sq_phase;
  logic [25:0] gm;
  logic        g_neg;
  logic [23:0] root2;
  logic [50:0] num;
  logic [24:0] den;
  logic [24:0] dv_rem;

  logic signed [24:0] da, db, dc, dd;
  logic [25:0] mul_a, mul_b;
  logic [51:0] mul_p;
  logic [49:0] max_p;
  logic [27:0] sq_rem_t, sq_trial, sq_rem_n;
  logic        sq_ge;
  logic [25:0] sq_root_n;
  logic signed [26:0] g_s;
  logic [25:0] dv_rem_t;
  logic        dv_ge;
  logic [24:0] dv_rem_n;
  logic [25:0] qc;
  logic signed [26:0] delta;
  logic signed [27:0] res_w;
  sample_t     res_sat;

  function automatic logic [24:0] mag_pos(input logic signed [24:0] x);
    mag_pos = x[24] ? 25'd0 : x;
  endfunction

  function automatic logic [24:0] mag_neg(input logic signed [24:0] x);
    mag_neg = x[24] ? 25'(-x) : 25'd0;
  endfunction

  always_comb begin
    da = 25'(jb.v) - 25'(jb.l);
    db = 25'(jb.r) - 25'(jb.v);
    dc = 25'(jb.v) - 25'(jb.u);
    dd = 25'(jb.d) - 25'(jb.v);
  end

  // shared multiplier
  always_comb begin
    mul_a = 26'(vm);
    mul_b = 26'(vm);
    if (state == B_MULQ) begin
      mul_b = gm;
    end else begin
      case (cnt)
        6'd0:    begin mul_a = 26'(x0); mul_b = 26'(x0); end
        6'd1:    begin mul_a = 26'(x1); mul_b = 26'(x1); end
        6'd2:    begin mul_a = 26'(x2); mul_b = 26'(x2); end
        6'd3:    begin mul_a = 26'(x3); mul_b = 26'(x3); end
        default: begin mul_a = 26'(vm); mul_b = 26'(vm); end
      endcase
    end
    mul_p = mul_a * mul_b;
    max_p = (hold0 > prod_r) ? hold0 : prod_r;
  end

  // one root bit per cycle
  always_comb begin
    sq_rem_t  = {sq_rem[25:0], sq_arg[51:50]};
    sq_trial  = {sq_root, 2'b01};
    sq_ge     = (sq_rem_t >= sq_trial);
    sq_rem_n  = sq_ge ? sq_rem_t - sq_trial : sq_rem_t;
    sq_root_n = {sq_root[24:0], sq_ge};
    g_s       = $signed({1'b0, sq_root_n}) - ONE_Q12;
  end

  // one quotient bit per cycle
  always_comb begin
    dv_rem_t = {dv_rem, num[50]};
    dv_ge    = (dv_rem_t >= {1'b0, den});
    dv_rem_n = dv_ge ? 25'(dv_rem_t - {1'b0, den}) : dv_rem_t[24:0];
  end

  // apply sign, subtract and saturate
  always_comb begin
    qc      = (|num[50:25]) ? 26'h2000000 : num[25:0];
    delta   = (jb.v[23] != g_neg) ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
    res_w   = 28'(jb.v) - 28'(delta);
    if (res_w > 28'sd8388607) begin
      res_sat = 24'sh7FFFFF;
    end else if (res_w < -28'sd8388608) begin
      res_sat = 24'sh800000;
    end else begin
      res_sat = res_w[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    out_valid  = 1'b0;
    case (state)
      B_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          state_next = B_PREP;
        end
      end
      B_PREP: begin
        state_next = (jb.v == '0) ? B_OUT : B_MUL;
      end
      B_MUL: begin
        if (cnt == 6'd5) begin
          state_next = B_SQRT;
        end
      end
      B_SQRT: begin
        if (cnt == 6'(SQ_ITERS - 1) && sq_phase) begin
          state_next = B_MULQ;
        end
      end
      B_MULQ: state_next = B_ADDQ;
      B_ADDQ: state_next = B_DIV;
      B_DIV: begin
        if (cnt == 6'(DIV_ITERS - 1)) begin
          state_next = B_DONE;
        end
      end
      B_DONE: state_next = B_OUT;
      B_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  assign frame_end = jb.frame_end;
  assign last      = jb.last;

  always_ff @(posedge clk) begin
    prod_r <= mul_p[49:0];
    case (state)
      B_IDLE: begin
        if (!job_empty) begin
          jb <= job_in;
        end
      end
      B_PREP: begin
        cnt     <= '0;
        phi_out <= '0;
        vm      <= jb.v[23] ? 24'(-jb.v) : jb.v;
        if (!jb.v[23]) begin
          x0 <= mag_pos(da);  x1 <= mag_neg(db);
          x2 <= mag_pos(dc);  x3 <= mag_neg(dd);
        end else begin
          x0 <= mag_neg(da);  x1 <= mag_pos(db);
          x2 <= mag_neg(dc);  x3 <= mag_pos(dd);
        end
      end
      B_MUL: begin
        cnt <= cnt + 6'd1;
        case (cnt)
          6'd1: hold0 <= prod_r;
          6'd2: m1    <= max_p;
          6'd3: hold0 <= prod_r;
          6'd4: sum   <= m1 + max_p;
          6'd5: begin
            rad2     <= prod_r + ONE_Q24;
            sq_arg   <= {2'b00, sum};
            sq_rem   <= '0;
            sq_root  <= '0;
            sq_phase <= 1'b0;
            cnt      <= '0;
          end
          default: ;
        endcase
      end
      B_SQRT: begin
        sq_arg  <= {sq_arg[49:0], 2'b00};
        sq_rem  <= sq_rem_n;
        sq_root <= sq_root_n;
        cnt     <= cnt + 6'd1;
        if (cnt == 6'(SQ_ITERS - 1)) begin
          cnt <= '0;
          if (!sq_phase) begin
            // gradient magnitude done: start the root of v*v + 1
            g_neg    <= g_s[26];
            gm       <= g_s[26] ? 26'(-g_s) : g_s[25:0];
            sq_arg   <= {2'b00, rad2};
            sq_rem   <= '0;
            sq_root  <= '0;
            sq_phase <= 1'b1;
          end else begin
            root2 <= sq_root_n[23:0];
          end
        end
      end
      B_ADDQ: begin
        // round to nearest: add half the divisor
        num    <= {1'b0, prod_r} + 51'(root2);
        den    <= {root2, 1'b0};
        dv_rem <= '0;
        cnt    <= '0;
      end
      B_DIV: begin
        num    <= {num[49:0], dv_ge};
        dv_rem <= dv_rem_n;
        cnt    <= cnt + 6'd1;
      end
      B_DONE: begin
        phi_out <= res_sat;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/level_set_reinit_stencil.sv
`default_nettype none
// ----------------------------------------------------------------------------
// level_set_reinit_stencil: streaming level-set reinitialization
// Raster-order Q12.12 level-set samples in, reinitialized samples out one
// row behind, last row interleaved with the row above it.
// ----------------------------------------------------------------------------
//  channel  handshake                 payload
//  in       in_valid / in_ready       phi_in
//  out      out_valid / out_ready     phi_out, frame_end, last
//  cfg      cfg_we                    cfg_index, cfg_data
//
//  The front end takes a new sample only when done with the last, waiting on
//  a full queue; it pushes 0 to 3 jobs into a 4-entry queue.
//  Each job runs in the back end as multiplier steps, two square roots and a
//  divide, one at a time (a zero center sample goes straight to the output);
//  only the square terms and products share the one multiplier.
//  Reset is synchronous; the row buffers need no clearing pass.
//  A stalled output holds the back end; the front end runs on until the
//  queue fills.
// ----------------------------------------------------------------------------
module level_set_reinit_stencil
  import lsr_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire sample_t     phi_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output sample_t          phi_out,
  output logic             frame_end,
  output logic             last,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_data
);

  logic [10:0] image_width;
  logic [11:0] image_height;
  logic        job_push, job_full, job_pop, job_empty;
  job_t        job_wr, job_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd640;
      image_height <= 12'd480;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[10:0];
        REG_HEIGHT: image_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  lsr_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .phi_in       (phi_in),
    .image_width  (image_width),
    .image_height (image_height),
    .job_push     (job_push),
    .job          (job_wr),
    .job_full     (job_full)
  );

  lsr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_wr),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (job_rd),
    .empty     (job_empty)
  );

  lsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job_pop   (job_pop),
    .job_in    (job_rd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .phi_out   (phi_out),
    .frame_end (frame_end),
    .last      (last)
  );

endmodule
`default_nettype wire

>>> hdl/lsr_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsr_check: port-level checks
// Output channel behavior and reset behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module lsr_check
  import lsr_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire sample_t     phi_out,
  input wire logic        frame_end,
  input wire logic        last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(phi_out) && $stable(frame_end)
      && $stable(last))
    else $error("stalled result changed");

  // the final pixel of a frame closes its item's results
  a_fend_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> last)
    else $error("frame end without last");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind level_set_reinit_stencil lsr_check u_check (.*);
`default_nettype wire
